>>> hdl/stcw_pkg.sv
// Shared types, constants and decode functions for the Shift-JIS text console writer.
`default_nettype none

package stcw_pkg;

  localparam int STCW_ROWS    = 25;
  localparam int STCW_COLUMNS = 80;

  localparam int CODE_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int BYTE_W     = 8;
  localparam int ACT_W      = 2;
  localparam int ROW_PORT_W = 5;
  localparam int COL_PORT_W = 7;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [ACT_W-1:0] ACT_PUT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SET  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TERMINAL_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_ATTR   = 1'b1;

  localparam logic [BYTE_W-1:0] BYTE_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] BYTE_QMARK = 8'h3f;

  localparam logic [CODE_W-1:0] SPACE_CODE = 16'h0020;
  localparam logic [CODE_W-1:0] WIDE_RIGHT = 16'h8000;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd225;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ATTR_W-1:0] attr;
  } cell_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FIN,
    ST_PUT,
    ST_FRESH,
    ST_WIDE,
    ST_WIDE2,
    ST_SCROLL,
    ST_SCROLL_END,
    ST_WAIT_OUT
  } st_t;

  function automatic logic is_lead(input logic [BYTE_W-1:0] b);
    return (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hef);
  endfunction

  function automatic logic is_trail(input logic [BYTE_W-1:0] b);
    return b >= 8'h40 && b <= 8'hfc && b != 8'h7f;
  endfunction

  function automatic logic [BYTE_W-1:0] single_map(input logic [BYTE_W-1:0] b);
    if (b >= 8'h80 && !(b >= 8'ha1 && b <= 8'hdf)) begin
      return BYTE_QMARK;
    end
    return b;
  endfunction

  function automatic logic [CODE_W-1:0] wide_code(input logic [BYTE_W-1:0] lead,
                                                  input logic [BYTE_W-1:0] trail);
    logic [8:0] r;
    logic [8:0] t;
    logic [8:0] rr;
    if (lead <= 8'h9f) begin
      r = {1'b0, lead} - 9'h071;
    end else begin
      r = {1'b0, lead} - 9'h0b1;
    end
    r = {r[7:0], 1'b1};
    t = {1'b0, trail};
    if (t > 9'h07f) begin
      t = t - 9'd1;
    end
    if (t >= 9'h09e) begin
      t = t - 9'h07d;
      r = r + 9'd1;
    end else begin
      t = t - 9'h01f;
    end
    rr = r - 9'h020;
    return {t[7:0], rr[7:0]};
  endfunction

endpackage

`default_nettype wire

>>> hdl/stcw_cell_ram.sv
// Character cell store: one write port, one registered read port.
`default_nettype none

module stcw_cell_ram
  import stcw_pkg::*;
#(
  parameter int DEPTH = STCW_ROWS * STCW_COLUMNS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire cell_t         wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output cell_t              rd_data
);

  cell_t mem_r [DEPTH];
  cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hdl/sjis_text_console_writer.sv
// Top level: Shift-JIS byte stream decoder and cursor control over the cell store.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in_      | slave     | in_tvalid/in_tready  | tuser: action; tdata: byte, row, column
//  out_     | master    | out_tvalid/out_tready| tuser: accepted; tdata: code, attr, row, col
//  cfg_     | write     | cfg_we               | cfg_index, cfg_wdata
//
// A wide character writes a left and a right cell; a bad trail writes '?' and is then
// decoded again as a fresh byte; a wrap before a character moves the cursor first, and a
// scroll moves the rows up by one, one cell copy a cycle through the single write port of
// the store, then blanks the last row.
// After reset a clearing pass fills the store before in_tready rises. A finished word
// waits in the output register while the next is taken, whose result waits in ST_WAIT_OUT.
`default_nettype none

module sjis_text_console_writer
  import stcw_pkg::*;
#(
  parameter int ROWS    = STCW_ROWS,
  parameter int COLUMNS = STCW_COLUMNS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // byte_value, cell_row, cell_column
  input  wire logic [ACT_W-1:0]      in_tuser,   // action
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // read_code, read_attribute,
                                                 // cursor_row_now, cursor_column_now
  output logic                       out_tuser,  // accepted
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);

  st_t                 state_r, state_nxt;
  st_t                 ret_r, ret_nxt;
  logic [AW-1:0]       sweep_r, sweep_nxt;
  logic                cp_v_r, cp_v_nxt;
  logic [AW-1:0]       cp_addr_r, cp_addr_nxt;
  logic                cp_copy_r, cp_copy_nxt;
  logic [RW-1:0]       cur_row_r, cur_row_nxt;
  logic [CW-1:0]       cur_col_r, cur_col_nxt;
  logic                lead_w_r, lead_w_nxt;
  logic [BYTE_W-1:0]   lead_r, lead_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic [BYTE_W-1:0]   ch_r, ch_nxt;
  logic                fresh_r, fresh_nxt;
  logic [CODE_W-1:0]   wcode_r, wcode_nxt;
  logic                ok_r, ok_nxt;
  logic                hit_r, hit_nxt;
  logic                term_r;
  logic [ATTR_W-1:0]   nattr_r;
  logic                out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]   out_code_r;
  logic [ATTR_W-1:0]   out_attr_r;
  logic [ROW_PORT_W-1:0] out_row_r;
  logic [COL_PORT_W-1:0] out_col_r;
  logic                out_ok_r;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  cell_t               wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  cell_t               rd_data;

  logic                fin;
  logic                out_free;
  logic                out_load;

  logic [BYTE_W-1:0]     in_byte;
  logic [ROW_PORT_W-1:0] in_row;
  logic [COL_PORT_W-1:0] in_col;
  logic                  in_range;
  logic [AW-1:0]         in_addr;
  logic                  in_trail_ok;

  logic [BYTE_W-1:0]   fb;
  logic                fb_lead;
  logic                fb_zero;

  logic                ch_lf, ch_cr, ch_bs, ch_print;
  logic                at_bottom, col_full, col_last, col_zero, lf_scroll;
  logic                put_wrap;
  logic [CW-1:0]       cell_col;
  logic [AW-1:0]       cell_addr;
  logic                sweep_last;
  logic                sweep_copy;
  logic [AW-1:0]       sweep_src;

  assign in_byte     = in_tdata[7:0];
  assign in_row      = in_tdata[12:8];
  assign in_col      = in_tdata[19:13];
  assign in_range    = (int'(in_row) < ROWS) && (int'(in_col) < COLUMNS);
  assign in_addr     = AW'(int'(in_row) * COLUMNS + int'(in_col));
  assign in_trail_ok = (in_byte != BYTE_NUL) && is_trail(in_byte);

  assign fb      = (state_r == ST_IDLE) ? in_byte : byte_r;
  assign fb_lead = is_lead(fb);
  assign fb_zero = (fb == BYTE_NUL);

  assign ch_lf     = (ch_r == BYTE_LF);
  assign ch_cr     = (ch_r == BYTE_CR);
  assign ch_bs     = (ch_r == BYTE_BS);
  assign ch_print  = !ch_lf && !ch_cr && !ch_bs;
  assign at_bottom = (cur_row_r == RW'(ROWS - 1));
  assign col_full  = (cur_col_r >= CW'(COLUMNS));
  assign col_last  = (cur_col_r >= CW'(COLUMNS - 1));
  assign col_zero  = (cur_col_r == '0);
  assign lf_scroll = at_bottom && term_r;
  assign put_wrap  = ch_print && col_full;

  assign cell_col  = (state_r == ST_PUT && ch_bs) ? cur_col_r - CW'(1) : cur_col_r;
  assign cell_addr = AW'(int'(cur_row_r) * COLUMNS + int'(cell_col));

  assign sweep_last = (sweep_r == AW'(CELLS - 1));
  assign sweep_copy = (int'(sweep_r) < CELLS - COLUMNS);
  assign sweep_src  = AW'(int'(sweep_r) + COLUMNS);

  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            ACT_READ: state_nxt = ST_READ;
            ACT_PUT: begin
              if (lead_w_r) begin
                state_nxt = in_trail_ok ? ST_WIDE : ST_PUT;
              end else if (fb_lead || fb_zero) begin
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_PUT;
              end
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_FRESH: begin
        if (!fb_lead && !fb_zero) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (ch_lf && lf_scroll) begin
          state_nxt = ST_SCROLL;
        end else if (put_wrap) begin
          state_nxt = lf_scroll ? ST_SCROLL : ST_PUT;
        end else if (fresh_r) begin
          state_nxt = ST_FRESH;
        end
      end
      ST_WIDE: begin
        if (col_last) begin
          state_nxt = lf_scroll ? ST_SCROLL : ST_WIDE;
        end else begin
          state_nxt = ST_WIDE2;
        end
      end
      ST_SCROLL: begin
        if (sweep_last) begin
          state_nxt = ST_SCROLL_END;
        end
      end
      ST_SCROLL_END: state_nxt = ret_r;
      ST_WAIT_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = state_r;
    endcase
    if (fin) begin
      state_nxt = out_free ? ST_IDLE : ST_WAIT_OUT;
    end
  end

  always_comb begin
    ret_nxt     = ret_r;
    sweep_nxt   = sweep_r;
    cp_v_nxt    = (state_r == ST_SCROLL);
    cp_addr_nxt = sweep_r;
    cp_copy_nxt = sweep_copy;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    lead_w_nxt  = lead_w_r;
    lead_nxt    = lead_r;
    byte_nxt    = byte_r;
    ch_nxt      = ch_r;
    fresh_nxt   = fresh_r;
    wcode_nxt   = wcode_r;
    ok_nxt      = ok_r;
    hit_nxt     = hit_r;
    wr_en       = 1'b0;
    wr_addr     = cell_addr;
    wr_data     = '{code: {8'h00, ch_r}, attr: nattr_r};
    rd_en       = 1'b0;
    rd_addr     = in_addr;
    fin         = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        wr_data   = '{code: SPACE_CODE, attr: RESET_ATTR};
        sweep_nxt = sweep_last ? '0 : sweep_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          byte_nxt = in_byte;
          ok_nxt   = 1'b0;
          hit_nxt  = 1'b0;
          case (in_tuser)
            ACT_READ: begin
              if (in_range) begin
                rd_en   = 1'b1;
                ok_nxt  = 1'b1;
                hit_nxt = 1'b1;
              end
            end
            ACT_SET: begin
              if (in_range) begin
                cur_row_nxt = RW'(in_row);
                cur_col_nxt = CW'(in_col);
                ok_nxt      = 1'b1;
              end
            end
            ACT_PUT: begin
              ok_nxt = 1'b1;
              if (lead_w_r) begin
                lead_w_nxt = 1'b0;
                wcode_nxt  = wide_code(lead_r, in_byte);
                ch_nxt     = BYTE_QMARK;
                fresh_nxt  = 1'b1;
              end else if (fb_lead) begin
                lead_w_nxt = 1'b1;
                lead_nxt   = fb;
              end else begin
                ch_nxt    = single_map(fb);
                fresh_nxt = 1'b0;
              end
            end
            default: ok_nxt = 1'b0;
          endcase
        end
      end
      ST_FRESH: begin
        if (fb_lead) begin
          lead_w_nxt = 1'b1;
          lead_nxt   = fb;
          fin        = 1'b1;
        end else if (fb_zero) begin
          fin = 1'b1;
        end else begin
          ch_nxt    = single_map(fb);
          fresh_nxt = 1'b0;
        end
      end
      ST_PUT: begin
        if (ch_lf) begin
          cur_col_nxt = '0;
          if (!at_bottom) begin
            cur_row_nxt = cur_row_r + RW'(1);
          end
          if (lf_scroll) begin
            ret_nxt = fresh_r ? ST_FRESH : ST_FIN;
          end else begin
            fin = !fresh_r;
          end
        end else if (put_wrap) begin
          cur_col_nxt = '0;
          if (!at_bottom) begin
            cur_row_nxt = cur_row_r + RW'(1);
          end
          ret_nxt = ST_PUT;
        end else begin
          if (ch_cr) begin
            cur_col_nxt = '0;
          end else if (ch_bs) begin
            if (!col_zero) begin
              cur_col_nxt = cur_col_r - CW'(1);
              wr_en       = 1'b1;
              wr_data     = '{code: SPACE_CODE, attr: nattr_r};
            end
          end else begin
            cur_col_nxt = cur_col_r + CW'(1);
            wr_en       = 1'b1;
          end
          fin = !fresh_r;
        end
      end
      ST_WIDE: begin
        if (col_last) begin
          cur_col_nxt = '0;
          if (!at_bottom) begin
            cur_row_nxt = cur_row_r + RW'(1);
          end
          ret_nxt = ST_WIDE;
        end else begin
          cur_col_nxt = cur_col_r + CW'(1);
          wr_en       = 1'b1;
          wr_data     = '{code: wcode_r, attr: nattr_r};
        end
      end
      ST_WIDE2: begin
        cur_col_nxt = cur_col_r + CW'(1);
        wr_en       = 1'b1;
        wr_data     = '{code: wcode_r | WIDE_RIGHT, attr: nattr_r};
        fin         = 1'b1;
      end
      ST_SCROLL: begin
        rd_en     = sweep_copy;
        rd_addr   = sweep_src;
        wr_en     = cp_v_r;
        wr_addr   = cp_addr_r;
        wr_data   = cp_copy_r ? rd_data : cell_t'{code: SPACE_CODE, attr: nattr_r};
        sweep_nxt = sweep_r + AW'(1);
      end
      ST_SCROLL_END: begin
        wr_en     = cp_v_r;
        wr_addr   = cp_addr_r;
        wr_data   = cp_copy_r ? rd_data : cell_t'{code: SPACE_CODE, attr: nattr_r};
        sweep_nxt = '0;
      end
      ST_READ: fin = 1'b1;
      ST_FIN:  fin = 1'b1;
      default: fin = 1'b0;
    endcase
  end

  assign out_load      = out_free && (fin || state_r == ST_WAIT_OUT);
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ret_r       <= ST_FIN;
      sweep_r     <= '0;
      cp_v_r      <= 1'b0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      lead_w_r    <= 1'b0;
      lead_r      <= '0;
      out_valid_r <= 1'b0;
      term_r      <= 1'b0;
      nattr_r     <= RESET_ATTR;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      sweep_r     <= sweep_nxt;
      cp_v_r      <= cp_v_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      lead_w_r    <= lead_w_nxt;
      lead_r      <= lead_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TERMINAL_MODE: term_r  <= cfg_wdata[0];
          CFG_NORMAL_ATTR:   nattr_r <= cfg_wdata[ATTR_W-1:0];
          default:           term_r  <= term_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r <= cp_addr_nxt;
    cp_copy_r <= cp_copy_nxt;
    byte_r    <= byte_nxt;
    ch_r      <= ch_nxt;
    fresh_r   <= fresh_nxt;
    wcode_r   <= wcode_nxt;
    ok_r      <= ok_nxt;
    hit_r     <= hit_nxt;
    if (out_load) begin
      out_code_r <= hit_r ? rd_data.code : '0;
      out_attr_r <= hit_r ? rd_data.attr : '0;
      out_row_r  <= ROW_PORT_W'(cur_row_nxt);
      out_col_r  <= COL_PORT_W'(cur_col_nxt);
      out_ok_r   <= ok_r;
    end
  end

  stcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_col_r, out_row_r, out_attr_r, out_code_r};
  assign out_tuser  = out_ok_r;

endmodule

`default_nettype wire
